### rtl/prsc_pkg.sv
`default_nettype none

package prsc_pkg;

  // default widths of the fixed-point data
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // saturation bound of the internal arithmetic
  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NEG_DUR   = 3'd1;
  localparam status_t ST_VEL_MISM  = 3'd2;
  localparam status_t ST_POS_MISM  = 3'd3;
  localparam status_t ST_POS_BOUND = 3'd4;
  localparam status_t ST_VEL_BOUND = 3'd5;
  localparam status_t ST_ACC_BOUND = 3'd6;

  // register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_POS_MIN  = 3'd0;
  localparam reg_idx_t REG_POS_MAX  = 3'd1;
  localparam reg_idx_t REG_VEL_MAX  = 3'd2;
  localparam reg_idx_t REG_ACC_MAX  = 3'd3;
  localparam reg_idx_t REG_TOL      = 3'd4;
  localparam reg_idx_t REG_LIM_OFF  = 3'd5;

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] x);
    return (x < -SMAX) ? -SMAX : x;
  endfunction

  // saturating add
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SMAX;
    else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -SMAX;
    else return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return sadd(a, -b);
  endfunction

  function automatic logic [63:0] uabs(input logic signed [63:0] x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // divide by 2^s, round to nearest, ties away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int s);
    logic [64:0] r;
    r = ({1'b0, uabs(x)} + (65'd1 << (s - 1))) >> s;
    return (x < 0) ? -$signed(r[63:0]) : $signed(r[63:0]);
  endfunction

  function automatic logic near(input logic signed [63:0] x, input logic signed [63:0] y,
                                input logic [15:0] tol);
    return uabs(ssub(x, y)) <= {48'd0, tol};
  endfunction

endpackage

`default_nettype wire

### rtl/parabolic_ramp_sequence_checker.sv
// Parabolic ramp sequence checker, one axis, signed fixed point.
// Input channel (in_valid_i / in_ready_o): one constant-acceleration segment per
// transfer, with first/last markers and the expected start and end values.
// Output channel (out_valid_o / out_ready_i): one transfer per segment carrying
// the sticky status of the sequence so far and sequence_done_o (= last marker).
// Configuration goes through the APB port (limits, tolerance, limit enable); the
// user must write it only while the block is idle, which the block does not enforce.
// One shared add/subtract unit runs a bit-serial multiplier (one bit per cycle,
// up to three products) and a restoring divider for the turning time (one
// quotient bit per cycle); a start mismatch skips these loops.
// One segment is processed at a time; in_ready_o is high only when idle, which
// begins as the previous result is registered.
// The result sits in an output register, so the next segment can be taken while
// it waits; if the receiver stalls with a result still held, the next result
// waits in its final step until the register frees.
// Reset clears the sticky status and the previous end position and velocity,
// and loads the register reset values (no limits, tolerance 1).
`default_nettype none

module parabolic_ramp_sequence_checker #(
  parameter int DATA_WIDTH = prsc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = prsc_pkg::FRAC_BITS_DEF,
  parameter int PDW        = (DATA_WIDTH > 32) ? 64 : 32,
  parameter int AW         = (DATA_WIDTH > 32) ? 6 : 5
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [AW-1:0]                paddr,
  input  wire  [PDW-1:0]               pwdata,
  output logic [PDW-1:0]               prdata,
  output logic                         pready,
  // segment input
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [DATA_WIDTH-1:0] ramp_start_pos_i,
  input  wire  signed [DATA_WIDTH-1:0] ramp_end_pos_i,
  input  wire  signed [DATA_WIDTH-1:0] ramp_start_vel_i,
  input  wire  signed [DATA_WIDTH-1:0] ramp_end_vel_i,
  input  wire  signed [DATA_WIDTH-1:0] accel_i,
  input  wire  signed [DATA_WIDTH-1:0] duration_i,
  input  wire                          first_ramp_i,
  input  wire                          last_ramp_i,
  input  wire  signed [DATA_WIDTH-1:0] expected_start_pos_i,
  input  wire  signed [DATA_WIDTH-1:0] expected_start_vel_i,
  input  wire  signed [DATA_WIDTH-1:0] expected_end_pos_i,
  input  wire  signed [DATA_WIDTH-1:0] expected_end_vel_i,
  // result output
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output prsc_pkg::status_t            status_o,
  output logic                         sequence_done_o
);
  import prsc_pkg::*;

  localparam int STRIDE_LOG = AW - 3;
  localparam int DIVB  = (DATA_WIDTH + FRAC_BITS < 63) ? DATA_WIDTH + FRAC_BITS : 63;
  localparam int MAXIT = (DIVB > DATA_WIDTH) ? DIVB : DATA_WIDTH;
  localparam int CNTW  = $clog2(MAXIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MUL1, S_VCHK, S_MUL2, S_XCHK, S_DIV, S_TZ,
    S_MUL3, S_XZ, S_BOUND, S_ENDCHK, S_DONE
  } state_e;

  function automatic logic signed [63:0] ext(input logic signed [DATA_WIDTH-1:0] x);
    return clamp64(64'(x));
  endfunction

  // configuration registers
  logic signed [DATA_WIDTH-1:0] pos_min_q, pos_max_q;
  logic [DATA_WIDTH-2:0]        vel_max_q, acc_max_q;
  logic [15:0]                  tol_q;
  logic                         lim_off_q;

  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[AW-1:STRIDE_LOG];
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      pos_max_q <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      vel_max_q <= '1;
      acc_max_q <= '1;
      tol_q     <= 16'd1;
      lim_off_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POS_MIN: pos_min_q <= pwdata[DATA_WIDTH-1:0];
        REG_POS_MAX: pos_max_q <= pwdata[DATA_WIDTH-1:0];
        REG_VEL_MAX: vel_max_q <= pwdata[DATA_WIDTH-2:0];
        REG_ACC_MAX: acc_max_q <= pwdata[DATA_WIDTH-2:0];
        REG_TOL:     tol_q     <= pwdata[15:0];
        REG_LIM_OFF: lim_off_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_POS_MIN: prdata = PDW'(pos_min_q);
      REG_POS_MAX: prdata = PDW'(pos_max_q);
      REG_VEL_MAX: prdata = PDW'(vel_max_q);
      REG_ACC_MAX: prdata = PDW'(acc_max_q);
      REG_TOL:     prdata = PDW'(tol_q);
      REG_LIM_OFF: prdata = PDW'(lim_off_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer and datapath state
  state_e state_q;
  logic signed [63:0] x0_q, x1_q, v0_q, v1_q, a_q, t_q, ee_pos_q, ee_vel_q;
  logic signed [63:0] refp_q, refv_q, bnd_lo_q, bnd_hi_q;
  logic signed [63:0] prev_pos_q, prev_vel_q;
  logic               first_q, last_q;
  status_t            code_q, sticky_q, status_q;
  logic               out_valid_q, done_q;

  // shared serial unit
  logic [63:0]      mcand_q;
  logic [64:0]      acc_q;
  logic [MAXIT-1:0] sh_q;
  logic [CNTW-1:0]  cnt_q;
  logic             neg_q;

  // combinational helpers
  logic signed [63:0] pos_min64, pos_max64, vel64, acc64, tol64;
  logic [63:0]        vabs, v1abs, tabs, aabs;
  logic [63+DATA_WIDTH:0] prod_mag;
  logic signed [63:0] prod_u, prod_s;
  logic signed [63:0] vcalc, inner_c, xcalc, xz;
  logic signed [63:0] pmin_t, pmax_t, vlim, alim;
  logic [63+FRAC_BITS:0] vsh;
  logic [DIVB-1:0]    dvd;
  logic [65:0]        alu_a, alu_b, alu_y;
  logic               alu_sub, is_div;
  logic [64:0]        rem_sh;
  logic [DIVB-1:0]    quo;
  logic               slot_free;
  status_t            seq_base, seq_new;

  always_comb begin
    pos_min64 = ext(pos_min_q);
    pos_max64 = ext(pos_max_q);
    vel64     = {{(65-DATA_WIDTH){1'b0}}, vel_max_q};
    acc64     = {{(65-DATA_WIDTH){1'b0}}, acc_max_q};
    tol64     = {48'd0, tol_q};
    vabs      = uabs(v0_q);
    v1abs     = uabs(v1_q);
    tabs      = uabs(t_q);
    aabs      = uabs(a_q);
    // saturated signed product of the serial multiplier
    prod_mag  = {acc_q[63:0], sh_q[MAXIT-1 -: DATA_WIDTH]};
    prod_u    = (|prod_mag[63+DATA_WIDTH:63]) ? SMAX : $signed({1'b0, prod_mag[62:0]});
    prod_s    = neg_q ? -prod_u : prod_u;
    vcalc     = sadd(v0_q, rshr(prod_s, FRAC_BITS));
    inner_c   = sadd(v0_q, rshr(prod_s, FRAC_BITS + 1));
    xcalc     = sadd(x0_q, rshr(prod_s, FRAC_BITS));
    xz        = sadd(x0_q, rshr(prod_s, FRAC_BITS + 1));
    // widened limits
    pmin_t    = ssub(pos_min64, tol64);
    pmax_t    = sadd(pos_max64, tol64);
    vlim      = sadd(vel64, tol64);
    alim      = sadd(acc64, tol64);
    // turning-time dividend |v0| * 2^FRAC_BITS, saturated
    vsh       = {vabs, {FRAC_BITS{1'b0}}};
    dvd       = (|vsh[63+FRAC_BITS:63]) ? DIVB'(SMAX) : DIVB'(vsh[62:0]);
    quo       = sh_q[DIVB-1:0];
    // shared adder: accumulate for multiply, trial subtract for divide
    is_div    = (state_q == S_DIV);
    rem_sh    = {acc_q[63:0], sh_q[DIVB-1]};
    alu_sub   = is_div;
    alu_a     = is_div ? {1'b0, rem_sh} : {1'b0, acc_q};
    alu_b     = (is_div || sh_q[0]) ? {2'b00, mcand_q} : 66'd0;
    alu_y     = alu_sub ? (alu_a + ~alu_b + 66'd1) : (alu_a + alu_b);
    // sticky status merge
    slot_free = !out_valid_q || out_ready_i;
    seq_base  = first_q ? ST_OK : sticky_q;
    seq_new   = (seq_base == ST_OK) ? code_q : seq_base;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign sequence_done_o = done_q;

  // sequencer, serial unit and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sticky_q    <= ST_OK;
      prev_pos_q  <= '0;
      prev_vel_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x0_q     <= ext(ramp_start_pos_i);
            x1_q     <= ext(ramp_end_pos_i);
            v0_q     <= ext(ramp_start_vel_i);
            v1_q     <= ext(ramp_end_vel_i);
            a_q      <= ext(accel_i);
            t_q      <= ext(duration_i);
            first_q  <= first_ramp_i;
            last_q   <= last_ramp_i;
            ee_pos_q <= ext(expected_end_pos_i);
            ee_vel_q <= ext(expected_end_vel_i);
            refp_q   <= first_ramp_i ? ext(expected_start_pos_i) : prev_pos_q;
            refv_q   <= first_ramp_i ? ext(expected_start_vel_i) : prev_vel_q;
            state_q  <= S_START;
          end
        end
        // start match, negative duration, launch a*t
        S_START: begin
          if (!near(x0_q, refp_q, tol_q)) begin
            code_q <= ST_POS_MISM; state_q <= S_DONE;
          end else if (!near(v0_q, refv_q, tol_q)) begin
            code_q <= ST_VEL_MISM; state_q <= S_DONE;
          end else if (t_q < -tol64) begin
            code_q <= ST_NEG_DUR; state_q <= S_DONE;
          end else begin
            mcand_q <= aabs;
            acc_q   <= '0;
            sh_q    <= MAXIT'(tabs[DATA_WIDTH-1:0]);
            neg_q   <= (a_q < 0) != (t_q < 0);
            cnt_q   <= CNTW'(DATA_WIDTH);
            state_q <= S_MUL1;
          end
        end
        S_MUL1, S_MUL2, S_MUL3: begin
          acc_q <= {1'b0, alu_y[64:1]};
          sh_q  <= {alu_y[0], sh_q[MAXIT-1:1]};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) begin
            unique case (state_q)
              S_MUL1:  state_q <= S_VCHK;
              S_MUL2:  state_q <= S_XCHK;
              default: state_q <= S_XZ;
            endcase
          end
        end
        // end velocity check, launch t*inner
        S_VCHK: begin
          if (!near(v1_q, vcalc, tol_q)) begin
            code_q <= ST_VEL_MISM; state_q <= S_DONE;
          end else begin
            mcand_q <= uabs(inner_c);
            acc_q   <= '0;
            sh_q    <= MAXIT'(tabs[DATA_WIDTH-1:0]);
            neg_q   <= (t_q < 0) != (inner_c < 0);
            cnt_q   <= CNTW'(DATA_WIDTH);
            state_q <= S_MUL2;
          end
        end
        // end position check; with limits on, pick extremes, launch the turning-time divide
        S_XCHK: begin
          if (!near(x1_q, xcalc, tol_q)) begin
            code_q <= ST_POS_MISM; state_q <= S_DONE;
          end else begin
            code_q <= ST_OK;
            if (lim_off_q) begin
              state_q <= S_ENDCHK;
            end else if (aabs <= 64'(tol64)) begin
              bnd_lo_q <= (v0_q > 0) ? x0_q : x1_q;
              bnd_hi_q <= (v0_q > 0) ? x1_q : x0_q;
              state_q  <= S_BOUND;
            end else begin
              bnd_lo_q <= (x0_q > x1_q) ? x1_q : x0_q;
              bnd_hi_q <= (x0_q > x1_q) ? x0_q : x1_q;
              if (v0_q == 0) begin
                state_q <= S_BOUND;
              end else begin
                mcand_q <= aabs;
                acc_q   <= '0;
                sh_q    <= MAXIT'(dvd);
                neg_q   <= (v0_q > 0) != (a_q < 0);
                cnt_q   <= CNTW'(DIVB);
                state_q <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          acc_q <= alu_y[65] ? rem_sh : alu_y[64:0];
          sh_q  <= MAXIT'({quo[DIVB-2:0], !alu_y[65]});
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) state_q <= S_TZ;
        end
        // turning point strictly inside: launch v0*tz
        S_TZ: begin
          if (!neg_q && (quo != '0) && (t_q > 0) && (64'(quo) < 64'(t_q))) begin
            mcand_q <= vabs;
            acc_q   <= '0;
            sh_q    <= MAXIT'(quo[DATA_WIDTH-1:0]);
            neg_q   <= (v0_q < 0);
            cnt_q   <= CNTW'(DATA_WIDTH);
            state_q <= S_MUL3;
          end else begin
            state_q <= S_BOUND;
          end
        end
        S_XZ: begin
          if (xz < bnd_lo_q) bnd_lo_q <= xz;
          if (xz > bnd_hi_q) bnd_hi_q <= xz;
          state_q <= S_BOUND;
        end
        S_BOUND: begin
          if (bnd_lo_q < pmin_t || bnd_hi_q > pmax_t) begin
            code_q <= ST_POS_BOUND; state_q <= S_DONE;
          end else if (vabs > 64'(vlim) || v1abs > 64'(vlim)) begin
            code_q <= ST_VEL_BOUND; state_q <= S_DONE;
          end else if (aabs > 64'(alim)) begin
            code_q <= ST_ACC_BOUND; state_q <= S_DONE;
          end else begin
            state_q <= S_ENDCHK;
          end
        end
        // end match on the last segment
        S_ENDCHK: begin
          if (last_q && !near(x1_q, ee_pos_q, tol_q)) code_q <= ST_POS_MISM;
          else if (last_q && !near(v1_q, ee_vel_q, tol_q)) code_q <= ST_VEL_MISM;
          state_q <= S_DONE;
        end
        // result transfer into the output register
        S_DONE: begin
          if (slot_free) begin
            status_q    <= seq_new;
            done_q      <= last_q;
            out_valid_q <= 1'b1;
            sticky_q    <= last_q ? ST_OK : seq_new;
            prev_pos_q  <= x1_q;
            prev_vel_q  <= v1_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a taken segment makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a segment transfer");

  // reported codes stay within the defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_ACC_BOUND)
    else $error("undefined status code");

  // serial multiply never runs past its operand width
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3)
      |-> (cnt_q != '0 && cnt_q <= CNTW'(DATA_WIDTH)))
    else $error("multiply counter out of range");

  // a finished sequence leaves the sticky status clear
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && slot_free && last_q) |=> (sticky_q == ST_OK && out_valid_q))
    else $error("sticky status not cleared at sequence end");

endmodule

`default_nettype wire

### tb/ramp_checker.sv
module ramp_checker
  import prsc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [4:0]  paddr,
  input  wire        [31:0] pwdata,
  input  wire               pready,
  input  wire               in_valid_i,
  input  wire               in_ready_o,
  input  wire signed [31:0] ramp_start_pos_i,
  input  wire signed [31:0] ramp_end_pos_i,
  input  wire signed [31:0] ramp_start_vel_i,
  input  wire signed [31:0] ramp_end_vel_i,
  input  wire signed [31:0] accel_i,
  input  wire signed [31:0] duration_i,
  input  wire               first_ramp_i,
  input  wire               last_ramp_i,
  input  wire signed [31:0] expected_start_pos_i,
  input  wire signed [31:0] expected_start_vel_i,
  input  wire signed [31:0] expected_end_pos_i,
  input  wire signed [31:0] expected_end_vel_i,
  input  wire               out_valid_o,
  input  wire               out_ready_i,
  input  status_t           status_o,
  input  wire               sequence_done_o,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int FRAC = 16;
  localparam longint LIM = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    status_t code;
    logic    done;
  } verdict_t;

  verdict_t verdict_q[$];

  // shadow copy of the limit registers
  longint lo_lim, hi_lim, vmax, amax, tol;
  bit     lim_off;

  // sequence state
  longint  last_pos, last_vel;
  status_t run_status;

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s, big;
    big = {1'b0, LIM};
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > big) return LIM;
    if (s < -big) return -LIM;
    return longint'(s[63:0]);
  endfunction

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic longint sat_mul(longint a, longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = pa * pb;
    if (p > LIM) return LIM;
    if (p < -LIM) return -LIM;
    return longint'(p[63:0]);
  endfunction

  // scale down by 2^s, nearest, ties away from zero
  function automatic longint round_shift(longint x, int s);
    longint unsigned r;
    r = (mag(x) + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit close(longint x, longint y);
    return mag(sat_add(x, -y)) <= tol;
  endfunction

  // consistency and bound checks of one segment
  function automatic status_t judge_segment(longint x0, longint x1, longint v0, longint v1,
                                            longint a, longint t);
    longint lo, hi, vc, xc, mid, tz, xz;
    if (t < -tol) return ST_NEG_DUR;
    vc = sat_add(v0, round_shift(sat_mul(a, t), FRAC));
    if (!close(v1, vc)) return ST_VEL_MISM;
    mid = sat_add(v0, round_shift(sat_mul(a, t), FRAC + 1));
    xc = sat_add(x0, round_shift(sat_mul(t, mid), FRAC));
    if (!close(x1, xc)) return ST_POS_MISM;
    if (lim_off) return ST_OK;
    if (mag(a) <= tol) begin
      // no turning point; ends taken in velocity order
      if (v0 > 0) begin
        lo = x0;
        hi = x1;
      end else begin
        lo = x1;
        hi = x0;
      end
    end else begin
      lo = (x0 > x1) ? x1 : x0;
      hi = (x0 > x1) ? x0 : x1;
      tz = sat_mul(-v0, longint'(1) << FRAC) / a;
      if (tz > 0 && tz < t) begin
        xz = sat_add(x0, round_shift(sat_mul(v0, tz), FRAC + 1));
        if (xz < lo) lo = xz;
        if (xz > hi) hi = xz;
      end
    end
    if (lo < sat_add(lo_lim, -tol) || hi > sat_add(hi_lim, tol)) return ST_POS_BOUND;
    if (mag(v0) > mag(sat_add(vmax, tol)) || mag(v1) > mag(sat_add(vmax, tol)))
      return ST_VEL_BOUND;
    if (mag(a) > mag(sat_add(amax, tol))) return ST_ACC_BOUND;
    return ST_OK;
  endfunction

  // one segment through the sequence state
  function automatic verdict_t advance_sequence();
    longint x0, x1, v0, v1, rp, rv;
    status_t code;
    verdict_t res;
    x0 = ramp_start_pos_i;
    x1 = ramp_end_pos_i;
    v0 = ramp_start_vel_i;
    v1 = ramp_end_vel_i;
    rp = first_ramp_i ? longint'(expected_start_pos_i) : last_pos;
    rv = first_ramp_i ? longint'(expected_start_vel_i) : last_vel;
    if (first_ramp_i) run_status = ST_OK;
    if (!close(x0, rp)) code = ST_POS_MISM;
    else if (!close(v0, rv)) code = ST_VEL_MISM;
    else code = judge_segment(x0, x1, v0, v1, accel_i, duration_i);
    if (code == ST_OK && last_ramp_i) begin
      if (!close(x1, expected_end_pos_i)) code = ST_POS_MISM;
      else if (!close(v1, expected_end_vel_i)) code = ST_VEL_MISM;
    end
    if (run_status == ST_OK) run_status = code;
    last_pos = x1;
    last_vel = v1;
    res.code = run_status;
    res.done = last_ramp_i;
    if (last_ramp_i) run_status = ST_OK;
    return res;
  endfunction

  // track register writes, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      lo_lim       = -64'sd2147483648;
      hi_lim       = 64'sd2147483647;
      vmax         = 64'sd2147483647;
      amax         = 64'sd2147483647;
      tol          = 1;
      lim_off      = 1'b1;
      last_pos     = 0;
      last_vel     = 0;
      run_status   = ST_OK;
      verdict_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_POS_MIN: lo_lim = $signed(pwdata);
          REG_POS_MAX: hi_lim = $signed(pwdata);
          REG_VEL_MAX: vmax = {33'd0, pwdata[30:0]};
          REG_ACC_MAX: amax = {33'd0, pwdata[30:0]};
          REG_TOL:     tol = {48'd0, pwdata[15:0]};
          REG_LIM_OFF: lim_off = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result transfer: status %0d", status_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = verdict_q.pop_front();
          if (want.code !== status_o || want.done !== sequence_done_o) begin
            if (fail_count_o < 10)
              $display("result mismatch: expected status %0d done %0b, got status %0d done %0b",
                       want.code, want.done, status_o, sequence_done_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_o) verdict_q.push_back(advance_sequence());
      pending_o <= verdict_q.size();
    end
  end

endmodule

### tb/tb_top.sv
module tb_top;
  import prsc_pkg::*;

  typedef struct packed {
    logic signed [31:0] x0, x1, v0, v1, acc, dur;
    logic               first, last;
    logic signed [31:0] esp, esv, eep, eev;
  } seg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] ramp_start_pos_i = '0, ramp_end_pos_i = '0;
  logic signed [31:0] ramp_start_vel_i = '0, ramp_end_vel_i = '0;
  logic signed [31:0] accel_i = '0, duration_i = '0;
  logic first_ramp_i = 1'b0, last_ramp_i = 1'b0;
  logic signed [31:0] expected_start_pos_i = '0, expected_start_vel_i = '0;
  logic signed [31:0] expected_end_pos_i = '0, expected_end_vel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  status_t status_o;
  logic sequence_done_o;
  int fail_count_o, pending_o;

  logic hold_go = 1'b0;
  int burst_left = 0;
  int idle_cycles = 0;

  // chain state of the well-formed sequences
  longint ch_pos = 0, ch_vel = 0;
  int ch_left = 0;

  parabolic_ramp_sequence_checker DUT (.*);
  ramp_checker u_checker (.*);

  initial forever #5 clk_i = ~clk_i;

  // receiver: stall pattern in windows, plus one long hold-off
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      if (hold_go) begin
        repeat (400) begin
          @(posedge clk_i);
          out_ready_i <= 1'b0;
        end
        hold_go = 1'b0;
      end
      mode = $urandom_range(0, 2);
      repeat (32) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 3000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic set_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one segment, bursts separated by random gaps
  task automatic send_seg(seg_t s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    ramp_start_pos_i <= s.x0;
    ramp_end_pos_i <= s.x1;
    ramp_start_vel_i <= s.v0;
    ramp_end_vel_i <= s.v1;
    accel_i <= s.acc;
    duration_i <= s.dur;
    first_ramp_i <= s.first;
    last_ramp_i <= s.last;
    expected_start_pos_i <= s.esp;
    expected_start_vel_i <= s.esv;
    expected_end_pos_i <= s.eep;
    expected_end_vel_i <= s.eev;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and let every result drain
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_o != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  function automatic seg_t mk(longint x0, longint x1, longint v0, longint v1, longint acc,
                              longint dur, bit first, bit last);
    seg_t s;
    s = '{x0: 32'(x0), x1: 32'(x1), v0: 32'(v0), v1: 32'(v1), acc: 32'(acc),
          dur: 32'(dur), first: first, last: last,
          esp: 32'(x0), esv: 32'(v0), eep: 32'(x1), eev: 32'(v1)};
    return s;
  endfunction

  function automatic longint scale_back(longint x, int s);
    longint r;
    r = ((x < 0 ? -x : x) + (longint'(1) << (s - 1))) >>> s;
    return (x < 0) ? -r : r;
  endfunction

  // next random segment: mostly chained sequences, some noise and corruption
  function automatic seg_t next_seg();
    seg_t s;
    longint acc, dur, v1, x1;
    bit first;
    int k;
    if ($urandom_range(0, 9) == 0) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom),
           $urandom, $urandom, $urandom, $urandom};
      return s;
    end
    first = 1'b0;
    if (ch_left == 0) begin
      ch_left = $urandom_range(1, 6);
      ch_pos = longint'($urandom_range(0, 32'h1000_0000)) - 64'sh0800_0000;
      ch_vel = longint'($urandom_range(0, 32'h0040_0000)) - 64'sh0020_0000;
      first = ($urandom_range(0, 7) != 0);
    end
    case ($urandom_range(0, 7))
      0: acc = 0;
      1: acc = longint'($urandom_range(0, 32)) - 16;
      default: acc = longint'($urandom_range(0, 32'h0008_0000)) - 64'sh0004_0000;
    endcase
    if ($urandom_range(0, 15) == 0) dur = -longint'($urandom_range(0, 40));
    else dur = longint'($urandom_range(0, 32'h0004_0000));
    v1 = ch_vel + scale_back(acc * dur, 16);
    x1 = ch_pos + scale_back(dur * (ch_vel + scale_back(acc * dur, 17)), 16);
    s = mk(ch_pos, x1, ch_vel, v1, acc, dur, first, ch_left == 1);
    if ($urandom_range(0, 7) == 0) s.eep = s.eep + $urandom_range(0, 64) - 32;
    ch_left--;
    ch_pos = x1;
    ch_vel = v1;
    if ($urandom_range(0, 6) == 0) begin
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 5))
        0: s.x0[k] = ~s.x0[k];
        1: s.x1[k] = ~s.x1[k];
        2: s.v0[k] = ~s.v0[k];
        3: s.v1[k] = ~s.v1[k];
        4: s.acc[k] = ~s.acc[k];
        default: s.dur[k] = ~s.dur[k];
      endcase
    end
    return s;
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset limits: no first segment, extremes, mismatch cases
    send_seg(mk(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_seg(mk(0, 0, 0, 0, 0, 65536, 1'b0, 1'b1));
    send_seg({{6{32'h7FFF_FFFF}}, 2'b00, {4{32'h7FFF_FFFF}}});
    send_seg({{6{32'h8000_0000}}, 2'b11, {4{32'h8000_0000}}});
    send_seg({{6{32'hFFFF_FFFF}}, 2'b11, {4{32'hFFFF_FFFF}}});
    send_seg(mk(0, 0, 0, 0, 0, -5 * 65536, 1'b1, 1'b1));
    send_seg(mk(0, 0, 65536, 3 * 65536, 0, 65536, 1'b1, 1'b1));
    send_seg(mk(7, 65536, 65536, 65536, 0, 65536, 1'b1, 1'b0));
    send_seg(mk(65536, 2 * 65536, 65536, 65536, 0, 65536, 1'b0, 1'b0));
    send_seg(mk(2 * 65536, 5 * 65536, 65536, 65536, 0, 65536, 1'b0, 1'b1));
    drain();

    // directed with limits on: turning point, velocity, acceleration, flat ramps
    set_reg(REG_POS_MIN, -32'sd1048576);
    set_reg(REG_POS_MAX, 32'sd1048576);
    set_reg(REG_VEL_MAX, 32'h0020_0000);
    set_reg(REG_ACC_MAX, 32'h0008_0000);
    set_reg(REG_TOL, 32'd16);
    set_reg(REG_LIM_OFF, 32'd0);
    send_seg(mk(0, 0, 32'h0040_0000, -32'sh0040_0000, -32'sh0040_0000, 32'h0002_0000,
                1'b1, 1'b1));
    send_seg(mk(0, 0, 32'h0040_0000, 32'h0040_0000, 0, 0, 1'b1, 1'b1));
    send_seg(mk(0, 0, 0, 0, 32'h0010_0000, 0, 1'b1, 1'b1));
    send_seg(mk(0, -65536, -65536, -65536, 0, 65536, 1'b1, 1'b1));
    send_seg(mk(0, 65536, 65536, 65536, 3, 65536, 1'b1, 1'b1));
    send_seg(mk(900000, 1100000, 0, 0, 0, 65536, 1'b1, 1'b1));
    drain();

    // random, moderate limits, with one long receiver hold-off
    set_reg(REG_POS_MIN, -32'sh0800_0000);
    set_reg(REG_POS_MAX, 32'sh0800_0000);
    set_reg(REG_VEL_MAX, 32'h0030_0000);
    set_reg(REG_ACC_MAX, 32'h0003_0000);
    set_reg(REG_TOL, $urandom_range(0, 200));
    repeat (40) send_seg(next_seg());
    hold_go <= 1'b1;
    repeat (60) send_seg(next_seg());
    drain();

    // random, extreme settings
    set_reg(REG_POS_MIN, 32'h8000_0000);
    set_reg(REG_POS_MAX, 32'h7FFF_FFFF);
    set_reg(REG_VEL_MAX, 32'h0);
    set_reg(REG_ACC_MAX, 32'h0);
    set_reg(REG_TOL, 32'd0);
    repeat (100) send_seg(next_seg());
    drain();

    set_reg(REG_POS_MIN, 32'h0);
    set_reg(REG_POS_MAX, 32'h0);
    set_reg(REG_VEL_MAX, 32'hFFFF_FFFF);
    set_reg(REG_ACC_MAX, 32'hFFFF_FFFF);
    set_reg(REG_TOL, 32'h0000_FFFF);
    repeat (100) send_seg(next_seg());
    drain();

    // random, limits off again
    set_reg(REG_LIM_OFF, 32'd1);
    set_reg(REG_TOL, $urandom_range(0, 65535));
    repeat (100) send_seg(next_seg());
    drain();

    if (fail_count_o == 0 && pending_o == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
